// ===== src/utf8_stream_decoder_top_defines.svh =====
// Assertion macros for the UTF-8 stream decoder.
// Used by utf8_stream_decoder_top; no other dependencies.
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define U8DEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define U8DEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8DEC_ASSERT(lbl, prop, msg)
`define U8DEC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/u8dec_pkg.sv =====
// Types, error codes and constants of the UTF-8 stream decoder.
// No dependencies; imported by utf8_stream_decoder_top.
package u8dec_pkg;

  localparam int CP_W = 21;

  // error bits of one decoded point
  localparam logic [3:0] ERR_NONE   = 4'b0000;
  localparam logic [3:0] ERR_STRAY  = 4'b0001;
  localparam logic [3:0] ERR_FOLLOW = 4'b0010;
  localparam logic [3:0] ERR_LEAD   = 4'b0100;
  localparam logic [3:0] ERR_LONG   = 4'b1000;

  // lead lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            point_valid;
    logic [3:0]      point_errors;
    logic [3:0]      string_errors;
    logic [15:0]     point_count;
    logic            end_of_string;
  } out_word_t;

  // smallest value that is not overlong for a lead length
  function automatic logic [CP_W-1:0] min_value(input logic [2:0] len);
    logic [CP_W-1:0] v;
    case (len)
      LEN_TWO:   v = 21'h000080;
      LEN_THREE: v = 21'h000800;
      LEN_FOUR:  v = 21'h010000;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic out_word_t mk_word(input logic [CP_W-1:0] cp, input logic valid,
                                        input logic [3:0] err, input logic [3:0] sticky,
                                        input logic [15:0] count, input logic last);
    out_word_t w;
    w.code_point    = cp;
    w.point_valid   = valid;
    w.point_errors  = err;
    w.string_errors = sticky;
    w.point_count   = count;
    w.end_of_string = last;
    return w;
  endfunction

endpackage

// ===== src/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder, top level.
// Depends on u8dec_pkg and utf8_stream_decoder_top_defines.svh.
//
// Usage:
//   in_*  : one byte of a UTF-8 string per word (data_byte, end_of_input).
//           A zero byte or end_of_input closes the string.
//   out_* : decoded code points, one per word, with per-point and per-string
//           error bits, a running point count and an end-of-string mark.
//   cfg_* : writes the replacement code point used for malformed input.
//   A byte is decoded in the cycle it is accepted and its zero, one or two
//   result words are written to a four-entry output queue; the first result
//   is shown on out_* once the words queued ahead of it have been taken.
//   Throughput: one byte per cycle while in_ready is high; a byte that breaks a
//   pending sequence makes two words, or one if it is a lead byte without end_of_input.
//   in_ready is high while the queue has room for two words, so a stalled
//   receiver holds at most four results before the input side stops.
//   Reset (rst_n low, synchronous) empties the queue, drops any partial
//   sequence, clears the string errors and count, and restores the
//   replacement point to U+FFFD. cfg_ready is always high.
module utf8_stream_decoder_top
  import u8dec_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_word_t        in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output out_word_t       out_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CP_W-1:0] cfg_data
);

`include "utf8_stream_decoder_top_defines.svh"

  // decoder state
  logic [CP_W-1:0]        repl_r;
  logic [CP_W-1:0]        acc_r, acc_nxt;
  logic [2:0]             lead_r, lead_nxt;
  logic [1:0]             pend_r, pend_nxt;
  logic [3:0]             sticky_r, sticky_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  // output queue
  out_word_t              fifo_r [4];
  logic [1:0]             wr_ptr_r, rd_ptr_r;
  logic [2:0]             fcnt_r;

  logic                   in_acc, out_pop;
  out_word_t              res0, res1;
  logic [1:0]             nres;

  assign cfg_ready = 1'b1;
  assign in_ready  = (fcnt_r <= 3'd2);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (fcnt_r != 3'd0);
  assign out_pop   = out_valid && out_ready;
  assign out_word  = fifo_r[rd_ptr_r];

  // decode one byte against the pending sequence
  always_comb begin
    logic [7:0]             b;
    logic                   e;
    logic [CP_W-1:0]        thr_old, thr_new, acc_shift, v, acc_new;
    logic [3:0]             brk_err, err;
    logic [3:0]             st_w;
    logic [COUNT_WIDTH-1:0] cnt_w;
    logic [2:0]             lead_new;
    logic                   clear_str, have_dec;
    out_word_t              dec;

    b         = in_word.data_byte;
    e         = in_word.end_of_input;
    thr_old   = min_value(lead_r);
    brk_err   = ERR_FOLLOW | ((repl_r < thr_old) ? ERR_LONG : ERR_NONE);
    acc_shift = {acc_r[CP_W-7:0], b[5:0]};
    thr_new   = '0;
    v         = '0;
    err       = ERR_NONE;
    acc_new   = '0;
    lead_new  = LEN_NONE;
    st_w      = sticky_r;
    cnt_w     = cnt_r;
    clear_str = 1'b0;
    have_dec  = 1'b0;
    dec       = '0;
    res0      = '0;
    res1      = '0;
    nres      = 2'd0;
    acc_nxt   = acc_r;
    lead_nxt  = lead_r;
    pend_nxt  = pend_r;

    if (b == 8'h00) begin
      // terminator: flush a pending sequence, else an end-only word
      nres      = 2'd1;
      clear_str = 1'b1;
      if (pend_r != 2'd0) begin
        st_w  = st_w | brk_err;
        cnt_w = (cnt_w == '1) ? cnt_w : cnt_w + 1'b1;
        res0  = mk_word(repl_r, 1'b1, brk_err, st_w, 16'(cnt_w), 1'b1);
      end else begin
        res0  = mk_word('0, 1'b0, ERR_NONE, st_w, 16'(cnt_w), 1'b1);
      end
    end else if (pend_r != 2'd0 && b[7:6] == 2'b10) begin
      // continuation byte of a pending sequence
      clear_str = e;
      if (pend_r == 2'd1) begin
        err      = (acc_shift < thr_old) ? ERR_LONG : ERR_NONE;
        v        = (acc_shift < thr_old) ? repl_r : acc_shift;
        st_w     = st_w | err;
        cnt_w    = (cnt_w == '1) ? cnt_w : cnt_w + 1'b1;
        res0     = mk_word(v, 1'b1, err, st_w, 16'(cnt_w), e);
        nres     = 2'd1;
        acc_nxt  = '0;
        lead_nxt = LEN_NONE;
        pend_nxt = 2'd0;
      end else begin
        acc_nxt  = acc_shift;
        pend_nxt = pend_r - 2'd1;
        if (e) begin
          st_w  = st_w | brk_err;
          cnt_w = (cnt_w == '1) ? cnt_w : cnt_w + 1'b1;
          res0  = mk_word(repl_r, 1'b1, brk_err, st_w, 16'(cnt_w), 1'b1);
          nres  = 2'd1;
        end
      end
    end else begin
      clear_str = e;
      // a non-continuation byte breaks the pending sequence
      if (pend_r != 2'd0) begin
        st_w     = st_w | brk_err;
        cnt_w    = (cnt_w == '1) ? cnt_w : cnt_w + 1'b1;
        res0     = mk_word(repl_r, 1'b1, brk_err, st_w, 16'(cnt_w), 1'b0);
        nres     = 2'd1;
        acc_nxt  = '0;
        lead_nxt = LEN_NONE;
        pend_nxt = 2'd0;
      end
      // decode the byte from scratch
      if (b[7] == 1'b0) begin
        st_w     = st_w;
        cnt_w    = (cnt_w == '1) ? cnt_w : cnt_w + 1'b1;
        dec      = mk_word(CP_W'(b), 1'b1, ERR_NONE, st_w, 16'(cnt_w), e);
        have_dec = 1'b1;
      end else if (b[7:6] == 2'b10) begin
        st_w     = st_w | ERR_STRAY;
        cnt_w    = (cnt_w == '1) ? cnt_w : cnt_w + 1'b1;
        dec      = mk_word(repl_r, 1'b1, ERR_STRAY, st_w, 16'(cnt_w), e);
        have_dec = 1'b1;
      end else if (b[7:3] == 5'b11111) begin
        st_w     = st_w | ERR_LEAD;
        cnt_w    = (cnt_w == '1) ? cnt_w : cnt_w + 1'b1;
        dec      = mk_word(repl_r, 1'b1, ERR_LEAD, st_w, 16'(cnt_w), e);
        have_dec = 1'b1;
      end else begin
        // lead byte opens a sequence
        if (b[7:5] == 3'b110) begin
          lead_new = LEN_TWO;
          acc_new  = CP_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          lead_new = LEN_THREE;
          acc_new  = CP_W'(b[3:0]);
        end else begin
          lead_new = LEN_FOUR;
          acc_new  = CP_W'(b[2:0]);
        end
        acc_nxt  = acc_new;
        lead_nxt = lead_new;
        pend_nxt = 2'(lead_new - 3'd1);
        if (e) begin
          thr_new  = min_value(lead_new);
          err      = ERR_FOLLOW | ((repl_r < thr_new) ? ERR_LONG : ERR_NONE);
          st_w     = st_w | err;
          cnt_w    = (cnt_w == '1) ? cnt_w : cnt_w + 1'b1;
          dec      = mk_word(repl_r, 1'b1, err, st_w, 16'(cnt_w), 1'b1);
          have_dec = 1'b1;
        end
      end
      if (have_dec) begin
        if (nres == 2'd0) begin
          res0 = dec;
        end else begin
          res1 = dec;
        end
        nres = nres + 2'd1;
      end
    end

    sticky_nxt = st_w;
    cnt_nxt    = cnt_w;
    // end of string clears the pending sequence, the string errors and the count
    if (clear_str) begin
      acc_nxt    = '0;
      lead_nxt   = LEN_NONE;
      pend_nxt   = 2'd0;
      sticky_nxt = ERR_NONE;
      cnt_nxt    = '0;
    end
  end

  // control and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r   <= REPL_RESET;
      acc_r    <= '0;
      lead_r   <= LEN_NONE;
      pend_r   <= 2'd0;
      sticky_r <= ERR_NONE;
      cnt_r    <= '0;
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      fcnt_r   <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        repl_r <= cfg_data;
      end
      if (in_acc) begin
        acc_r    <= acc_nxt;
        lead_r   <= lead_nxt;
        pend_r   <= pend_nxt;
        sticky_r <= sticky_nxt;
        cnt_r    <= cnt_nxt;
        wr_ptr_r <= wr_ptr_r + nres;
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      fcnt_r <= fcnt_r + (in_acc ? 3'(nres) : 3'd0) - (out_pop ? 3'd1 : 3'd0);
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (nres != 2'd0) begin
        fifo_r[wr_ptr_r] <= res0;
      end
      if (nres == 2'd2) begin
        fifo_r[wr_ptr_r + 2'd1] <= res1;
      end
    end
  end

  `U8DEC_ASSERT_ALWAYS(a_fifo_bound, (!rst_n || fcnt_r <= 3'd4), "output queue overflow")
  `U8DEC_ASSERT(a_pend_lead, (pend_r != 2'd0) |-> (lead_r >= LEN_TWO && 3'(pend_r) < lead_r), "pending count does not fit lead length")
  `U8DEC_ASSERT(a_zero_clears, (in_acc && in_word.data_byte == 8'h00) |=> (pend_r == 2'd0 && sticky_r == ERR_NONE && cnt_r == '0), "terminator did not clear string state")
  `U8DEC_ASSERT(a_push_room, in_acc |-> (fcnt_r + 3'(nres) <= 3'd4 + (out_pop ? 3'd1 : 3'd0)), "result push without queue room")

endmodule
